// ===== rtl/core/bloom_filter_probe_engine_defines.svh =====
// Assertion macros for the bloom filter probe engine.
`ifndef BLOOM_FILTER_PROBE_ENGINE_DEFINES_SVH
`define BLOOM_FILTER_PROBE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define BFPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfpe assertion failed");

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define BFPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfpe assertion failed");

`endif

// ===== rtl/core/bfpe_pkg.sv =====
// Shared widths, register indexes and defaults of the bloom filter probe engine.
package bfpe_pkg;

  localparam int HASH_W      = 32;
  localparam int NBITS_W     = 17;
  localparam int NHASH_W     = 6;
  localparam int COUNT_W     = 32;
  localparam int BYTE_W      = 8;

  // Remainder unit: quotient bits retired per cycle.
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = HASH_W / MOD_DIGIT_W;
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_BITS   = 4'd0,
    CFG_NUM_HASHES = 4'd1
  } cfg_reg_e;

  localparam int DEF_NUM_BITS   = 65536;
  localparam int DEF_NUM_HASHES = 7;
  localparam int DEF_MAX_BITS   = 65536;
  localparam int DEF_MAX_HASHES = 32;

endpackage

// ===== rtl/core/bfpe_if.sv =====
// Handshake channels of the bloom filter probe engine: request, response, config.
interface bfpe_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [bfpe_pkg::HASH_W-1:0] hash_first;
  logic [bfpe_pkg::HASH_W-1:0] hash_second;

  modport source (output valid, action, hash_first, hash_second, input ready);
  modport sink   (input valid, action, hash_first, hash_second, output ready);
endinterface

interface bfpe_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         possibly_present;
  logic [bfpe_pkg::COUNT_W-1:0] inserted_count;
  logic [bfpe_pkg::NBITS_W-1:0] set_bit_count;
  logic [bfpe_pkg::COUNT_W-1:0] clash_count;

  modport source (output valid, possibly_present, inserted_count, set_bit_count,
                  clash_count, input ready);
  modport sink   (input valid, possibly_present, inserted_count, set_bit_count,
                  clash_count, output ready);
endinterface

interface bfpe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bfpe_pkg::CFG_IDX_W-1:0]  index;
  logic [bfpe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bfpe_mod_unit.sv =====
// Iterative remainder unit: 32-bit dividend mod a 17-bit modulus, a few bits per cycle.
module bfpe_mod_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bfpe_pkg::HASH_W-1:0]  dividend_i,
  input  logic [bfpe_pkg::NBITS_W-1:0] modulus_i,
  output logic                         done_o,
  output logic [bfpe_pkg::NBITS_W-1:0] rem_o
);

  logic [bfpe_pkg::HASH_W-1:0]    div_q, div_d;
  logic [bfpe_pkg::NBITS_W-1:0]   rem_q, rem_d;
  logic [bfpe_pkg::MOD_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic                           last_step;

  assign last_step = (cnt_q == bfpe_pkg::MOD_CNT_W'(bfpe_pkg::MOD_STEPS - 1));

  // Restoring division over one digit: shift in a bit, subtract when it fits.
  always_comb begin
    logic [bfpe_pkg::NBITS_W:0] part;
    logic [bfpe_pkg::NBITS_W-1:0] r;
    r = rem_q;
    for (int j = 0; j < bfpe_pkg::MOD_DIGIT_W; j++) begin
      part = {r, div_q[bfpe_pkg::HASH_W-1-j]};
      if (part >= {1'b0, modulus_i}) begin
        part = part - {1'b0, modulus_i};
      end
      r = part[bfpe_pkg::NBITS_W-1:0];
    end
    rem_d = r;
    div_d = div_q << bfpe_pkg::MOD_DIGIT_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/bloom_filter_probe_engine.sv =====
// Bloom filter probe engine, double hashing, over a byte-row bit store.
// Each probe is 8 remainder steps, a store read and an update; one item at a time,
// ready again when it is done.
// The shared remainder unit sets the probe time; a lookup stops at the first clear bit.
// Reset: clears the counters, loads the default settings, then sweeps the store one
// byte row a cycle over every row, with no item taken meanwhile.
module bloom_filter_probe_engine #(
  parameter int MAX_BITS   = bfpe_pkg::DEF_MAX_BITS,
  parameter int MAX_HASHES = bfpe_pkg::DEF_MAX_HASHES
) (
  input  logic clk_i,
  input  logic rst_ni,
  bfpe_req_if.sink   in_i,
  bfpe_rsp_if.source out_o,
  bfpe_cfg_if.sink   cfg_i
);

  `include "bloom_filter_probe_engine_defines.svh"

  localparam int IDX_W  = $clog2(MAX_BITS);
  localparam int EXT_W  = (IDX_W > bfpe_pkg::NBITS_W) ? IDX_W : bfpe_pkg::NBITS_W;
  localparam int BSEL_W = $clog2(bfpe_pkg::BYTE_W);
  localparam int ROWS   = (MAX_BITS + bfpe_pkg::BYTE_W - 1) / bfpe_pkg::BYTE_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW     = $clog2(MAX_HASHES + 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_MOD    = 5'b00100,
    S_UPDATE = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [bfpe_pkg::NBITS_W-1:0] num_bits_q;
  logic [bfpe_pkg::NHASH_W-1:0] num_hashes_q;

  logic [bfpe_pkg::NBITS_W-1:0] m_q, m_eff;
  logic [KW-1:0]                k_q, k_eff, i_q, i_d;
  logic                         act_q, present_q, present_d;
  logic [bfpe_pkg::HASH_W-1:0]  comb_q, comb_d, h2_q, comb_next;
  logic [IDX_W-1:0]             idx_q, idx_new;
  logic [EXT_W-1:0]             rem_ext;

  logic [bfpe_pkg::COUNT_W-1:0] keys_q, keys_d, coll_q, coll_d;
  logic [bfpe_pkg::NBITS_W-1:0] bits_q, bits_d;

  logic                         out_valid_q;
  logic                         out_present_q;
  logic [bfpe_pkg::COUNT_W-1:0] out_keys_q, out_coll_q;
  logic [bfpe_pkg::NBITS_W-1:0] out_bits_q;
  logic                         out_load;

  logic [ROW_W-1:0]             clr_q;
  logic [bfpe_pkg::BYTE_W-1:0]  store_mem [ROWS];
  logic [bfpe_pkg::BYTE_W-1:0]  rd_q, mem_wdata;
  logic [ROW_W-1:0]             mem_waddr, mem_raddr;
  logic                         mem_we, mem_re;
  logic                         probe_bit;

  logic                         in_take;
  logic                         mod_start, mod_done;
  logic [bfpe_pkg::HASH_W-1:0]  mod_dividend;
  logic [bfpe_pkg::NBITS_W-1:0] mod_rem;

  bfpe_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .modulus_i  (m_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Zero modulus behaves as one; clamp the settings to MAX_BITS and MAX_HASHES.
  always_comb begin
    if (num_bits_q == '0) begin
      m_eff = bfpe_pkg::NBITS_W'(1);
    end else if (32'(num_bits_q) > 32'(MAX_BITS)) begin
      m_eff = bfpe_pkg::NBITS_W'(MAX_BITS);
    end else begin
      m_eff = num_bits_q;
    end
    if (32'(num_hashes_q) > 32'(MAX_HASHES)) begin
      k_eff = KW'(MAX_HASHES);
    end else begin
      k_eff = KW'(num_hashes_q);
    end
  end

  assign rem_ext   = EXT_W'(mod_rem);
  assign idx_new   = rem_ext[IDX_W-1:0];
  assign comb_next = comb_q + h2_q;
  assign probe_bit = rd_q[idx_q[BSEL_W-1:0]];
  assign out_load  = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    comb_d       = comb_q;
    present_d    = present_q;
    keys_d       = keys_q;
    bits_d       = bits_q;
    coll_d       = coll_q;
    mod_start    = 1'b0;
    mod_dividend = comb_next;
    mem_we       = 1'b0;
    mem_waddr    = ROW_W'(idx_q >> BSEL_W);
    mem_wdata    = rd_q;
    mem_re       = 1'b0;
    mem_raddr    = ROW_W'(idx_new >> BSEL_W);

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == ROW_W'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          i_d          = '0;
          comb_d       = in_i.hash_first;
          present_d    = 1'b1;
          mod_dividend = in_i.hash_first;
          if (k_eff == '0) begin
            state_d = S_FINISH;
          end else begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          mem_re  = 1'b1;
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        i_d = i_q + 1'b1;
        if (!act_q) begin
          if (probe_bit) begin
            if (coll_q != '1) begin
              coll_d = coll_q + 1'b1;
            end
          end else begin
            mem_we    = 1'b1;
            mem_wdata = rd_q | (bfpe_pkg::BYTE_W'(1) << idx_q[BSEL_W-1:0]);
            if (bits_q != '1) begin
              bits_d = bits_q + 1'b1;
            end
          end
        end
        // Stop a lookup at the first clear bit.
        if (act_q && !probe_bit) begin
          present_d = 1'b0;
          state_d   = S_FINISH;
        end else if (i_d == k_q) begin
          state_d = S_FINISH;
        end else begin
          comb_d    = comb_next;
          mod_start = 1'b1;
          state_d   = S_MOD;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          if (!act_q && (keys_q != '1)) begin
            keys_d = keys_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      num_bits_q   <= bfpe_pkg::NBITS_W'(bfpe_pkg::DEF_NUM_BITS);
      num_hashes_q <= bfpe_pkg::NHASH_W'(bfpe_pkg::DEF_NUM_HASHES);
      keys_q       <= '0;
      bits_q       <= '0;
      coll_q       <= '0;
      i_q          <= '0;
      present_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      keys_q    <= keys_d;
      bits_q    <= bits_d;
      coll_q    <= coll_d;
      i_q       <= i_d;
      present_q <= present_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          bfpe_pkg::CFG_NUM_BITS:   num_bits_q   <= cfg_i.data[bfpe_pkg::NBITS_W-1:0];
          bfpe_pkg::CFG_NUM_HASHES: num_hashes_q <= cfg_i.data[bfpe_pkg::NHASH_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-item operands and the response payload.
  always_ff @(posedge clk_i) begin
    comb_q <= comb_d;
    if (in_take) begin
      act_q <= in_i.action;
      h2_q  <= in_i.hash_second;
      m_q   <= m_eff;
      k_q   <= k_eff;
    end
    if (mod_done) begin
      idx_q <= idx_new;
    end
    if (out_load) begin
      out_present_q <= act_q && present_q;
      out_keys_q    <= keys_d;
      out_bits_q    <= bits_q;
      out_coll_q    <= coll_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= store_mem[mem_raddr];
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.possibly_present = out_present_q;
  assign out_o.inserted_count   = out_keys_q;
  assign out_o.set_bit_count    = out_bits_q;
  assign out_o.clash_count      = out_coll_q;

  `BFPE_ASSERT_NOW(a_done_in_mod, mod_done, state_q == S_MOD)
  `BFPE_ASSERT_NOW(a_idx_below_m, state_q == S_UPDATE, 32'(idx_q) < 32'(m_q))
  `BFPE_ASSERT_NEXT(a_finish_loads_out, out_load, out_valid_q && state_q == S_IDLE)

endmodule

// ===== tb/bloom_filter_probe_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the bloom filter probe engine: directed and random probes.
module bloom_filter_probe_engine_tb;

  localparam int unsigned FILTER_BITS   = bfpe_pkg::DEF_MAX_BITS;
  localparam int unsigned FILTER_HASHES = bfpe_pkg::DEF_MAX_HASHES;
  localparam int unsigned PHASE_ITEMS   = 81;
  localparam int unsigned NUM_PHASES    = 9;
  localparam int unsigned LONG_STALL    = 600;
  // slowest item runs k probes, with k at most 32
  localparam int unsigned SETTLE_CYCLES = 400;
  // reset sweep, then every item at 32 probes behind the slowest receiver, several times over
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned KEY_POOL_MAX  = 64;

  localparam logic [bfpe_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = bfpe_pkg::CFG_IDX_W'(9);
  localparam logic [bfpe_pkg::NBITS_W-1:0]   SET_COUNT_MAX = '1;
  localparam logic [bfpe_pkg::COUNT_W-1:0]   COUNT_MAX     = '1;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  typedef struct packed {
    action_e                       action;
    logic [bfpe_pkg::HASH_W-1:0]   hash_first;
    logic [bfpe_pkg::HASH_W-1:0]   hash_second;
  } probe_req_t;

  typedef struct packed {
    logic                          possibly_present;
    logic [bfpe_pkg::COUNT_W-1:0]  inserted_count;
    logic [bfpe_pkg::NBITS_W-1:0]  set_bit_count;
    logic [bfpe_pkg::COUNT_W-1:0]  clash_count;
  } probe_rsp_t;

  logic clk_i;
  logic rst_ni;

  bfpe_req_if req_ch ();
  bfpe_rsp_if rsp_ch ();
  bfpe_cfg_if cfg_ch ();

  bloom_filter_probe_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  // filter state as the block should hold it
  bit                           filter_bits [FILTER_BITS];
  logic [bfpe_pkg::NBITS_W-1:0] mdl_num_bits   = bfpe_pkg::NBITS_W'(bfpe_pkg::DEF_NUM_BITS);
  logic [bfpe_pkg::NHASH_W-1:0] mdl_num_hashes = bfpe_pkg::NHASH_W'(bfpe_pkg::DEF_NUM_HASHES);
  logic [bfpe_pkg::COUNT_W-1:0] mdl_inserted   = '0;
  logic [bfpe_pkg::NBITS_W-1:0] mdl_set_bits   = '0;
  logic [bfpe_pkg::COUNT_W-1:0] mdl_collisions = '0;

  probe_req_t                    probe_requests[$];
  probe_rsp_t                    awaited_results[$];
  logic [2*bfpe_pkg::HASH_W-1:0] inserted_keys[$];

  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 74;
  logic        stall_arm     = 1'b0;
  int unsigned stall_left    = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned inserts_done  = 0;
  int unsigned lookups_done  = 0;
  int unsigned present_hits  = 0;
  int unsigned reg_writes    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Probe the filter for one request and update the state it changes.
  function automatic probe_rsp_t apply_probe(probe_req_t rq);
    probe_rsp_t                  rs;
    int unsigned                 span;
    int unsigned                 probes;
    int unsigned                 i;
    int unsigned                 slot;
    logic [bfpe_pkg::HASH_W-1:0] mix;
    span   = (mdl_num_bits == 0) ? 1 :
             ((mdl_num_bits > FILTER_BITS) ? FILTER_BITS : mdl_num_bits);
    probes = (mdl_num_hashes > FILTER_HASHES) ? FILTER_HASHES : mdl_num_hashes;
    rs = '0;
    if (rq.action == ACT_INSERT) begin
      for (i = 0; i < probes; i++) begin
        mix  = rq.hash_first + i * rq.hash_second;
        slot = mix % span;
        if (filter_bits[slot]) begin
          if (mdl_collisions != COUNT_MAX) mdl_collisions++;
        end else begin
          filter_bits[slot] = 1'b1;
          if (mdl_set_bits != SET_COUNT_MAX) mdl_set_bits++;
        end
      end
      if (mdl_inserted != COUNT_MAX) mdl_inserted++;
      inserts_done++;
    end else begin
      rs.possibly_present = 1'b1;
      i = 0;
      // stop at the first clear bit
      while (i < probes && rs.possibly_present) begin
        mix = rq.hash_first + i * rq.hash_second;
        if (!filter_bits[mix % span]) rs.possibly_present = 1'b0;
        i++;
      end
      lookups_done++;
      if (rs.possibly_present) present_hits++;
    end
    rs.inserted_count = mdl_inserted;
    rs.set_bit_count  = mdl_set_bits;
    rs.clash_count    = mdl_collisions;
    return rs;
  endfunction

  function automatic logic [bfpe_pkg::HASH_W-1:0] random_hash();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly inserts and lookups of keys inserted earlier, the rest random lookups.
  function automatic probe_req_t next_random_probe();
    probe_req_t  rq;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45 || inserted_keys.size() == 0) begin
      rq.action      = ACT_INSERT;
      rq.hash_first  = random_hash();
      rq.hash_second = random_hash();
      inserted_keys.push_back({rq.hash_first, rq.hash_second});
      if (inserted_keys.size() > KEY_POOL_MAX) void'(inserted_keys.pop_front());
    end else if (pick < 80) begin
      rq.action = ACT_LOOKUP;
      {rq.hash_first, rq.hash_second} =
        inserted_keys[$urandom_range(inserted_keys.size() - 1)];
    end else begin
      rq.action      = ACT_LOOKUP;
      rq.hash_first  = random_hash();
      rq.hash_second = random_hash();
    end
    return rq;
  endfunction

  function automatic void check_field(string field, logic [bfpe_pkg::COUNT_W-1:0] want,
                                      logic [bfpe_pkg::COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_probe(action_e act, logic [bfpe_pkg::HASH_W-1:0] h1,
                           logic [bfpe_pkg::HASH_W-1:0] h2);
    probe_requests.push_back('{action: act, hash_first: h1, hash_second: h2});
  endtask

  task automatic write_register(logic [bfpe_pkg::CFG_IDX_W-1:0] idx,
                                logic [bfpe_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      bfpe_pkg::CFG_NUM_BITS:   mdl_num_bits   = value[bfpe_pkg::NBITS_W-1:0];
      bfpe_pkg::CFG_NUM_HASHES: mdl_num_hashes = value[bfpe_pkg::NHASH_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Hold until every queued item went in and every result came back.
  task automatic wait_drained();
    while (probe_requests.size() != 0 || awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Request driver: hold an offered item until it is taken.
  always @(posedge clk_i) begin : drive_requests
    logic taken;
    taken = rst_ni && req_ch.valid && req_ch.ready;
    if (taken) awaited_results.push_back(apply_probe(probe_requests.pop_front()));
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || taken) begin
      if (probe_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid       <= 1'b1;
        req_ch.action      <= probe_requests[0].action;
        req_ch.hash_first  <= probe_requests[0].hash_first;
        req_ch.hash_second <= probe_requests[0].hash_second;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk_i) begin
    if (stall_arm) begin
      stall_left <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin : check_results
    probe_rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: expected no result, got present %0b inserted %0h set %0h coll %0h",
                 $time, rsp_ch.possibly_present, rsp_ch.inserted_count,
                 rsp_ch.set_bit_count, rsp_ch.clash_count);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("possibly_present", bfpe_pkg::COUNT_W'(want.possibly_present),
                    bfpe_pkg::COUNT_W'(rsp_ch.possibly_present));
        check_field("inserted_count", want.inserted_count, rsp_ch.inserted_count);
        check_field("set_bit_count", bfpe_pkg::COUNT_W'(want.set_bit_count),
                    bfpe_pkg::COUNT_W'(rsp_ch.set_bit_count));
        check_field("clash_count", want.clash_count, rsp_ch.clash_count);
        results_seen++;
      end
    end
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d items pending, %0d results awaited", $time,
               probe_requests.size(), awaited_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int          phase_bits   [NUM_PHASES] = '{8, -1, 65536, 64, 1, -2, 131071, 1000, -1};
    int          phase_hashes [NUM_PHASES] = '{3, -1, 32, -1, 2, -1, 63, 5, -3};
    int unsigned bits_val;
    int unsigned hashes_val;
    logic [bfpe_pkg::CFG_DATA_W-1:0] junk;
    int unsigned ph;
    int unsigned n;

    rst_ni             = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.action      = ACT_INSERT;
    req_ch.hash_first  = '0;
    req_ch.hash_second = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = bfpe_pkg::CFG_NUM_BITS;
    cfg_ch.data        = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: 65536 bits, 7 probes
    @(negedge clk_i);
    add_probe(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    add_probe(ACT_INSERT, 32'h0000_0000, 32'h0000_0000);  // same bit probed every time
    add_probe(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    add_probe(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // index sum wraps
    add_probe(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_probe(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0001);
    add_probe(ACT_INSERT, 32'h1234_5678, 32'h9ABC_DEF0);
    add_probe(ACT_LOOKUP, 32'h1234_5678, 32'h9ABC_DEF0);
    wait_drained();

    // zero size counts as one bit; zero probes
    write_register(bfpe_pkg::CFG_NUM_BITS, 32'h0000_0000);
    write_register(bfpe_pkg::CFG_NUM_HASHES, 32'h0000_0000);
    @(negedge clk_i);
    add_probe(ACT_INSERT, $urandom(), $urandom());
    add_probe(ACT_LOOKUP, $urandom(), $urandom());
    wait_drained();

    write_register(bfpe_pkg::CFG_NUM_HASHES, 32'h0000_0001);
    @(negedge clk_i);
    add_probe(ACT_LOOKUP, 32'h0000_0005, 32'h0000_0007);
    add_probe(ACT_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    wait_drained();

    // oversized registers saturate; a write to an unknown index is dropped
    write_register(bfpe_pkg::CFG_NUM_BITS, 32'h0001_FFFF);
    write_register(bfpe_pkg::CFG_NUM_HASHES, 32'h0000_003F);
    write_register(CFG_SPARE_IDX, 32'hFFFF_FFFF);
    @(negedge clk_i);
    add_probe(ACT_INSERT, 32'h8000_0000, 32'h0000_0800);
    add_probe(ACT_LOOKUP, 32'h8000_0000, 32'h0000_0800);
    add_probe(ACT_LOOKUP, 32'h8000_0000, 32'h0000_0801);
    wait_drained();

    write_register(bfpe_pkg::CFG_NUM_BITS, 32'd8);
    write_register(bfpe_pkg::CFG_NUM_HASHES, 32'd32);
    @(negedge clk_i);
    add_probe(ACT_INSERT, 32'h0000_0003, 32'h0000_0001);
    add_probe(ACT_LOOKUP, 32'hDEAD_BEEF, 32'h0001_2345);
    wait_drained();

    // set high bits, then shrink the filter below them
    write_register(bfpe_pkg::CFG_NUM_BITS, 32'd65536);
    write_register(bfpe_pkg::CFG_NUM_HASHES, 32'd4);
    @(negedge clk_i);
    add_probe(ACT_INSERT, 32'hFFFF_FFF0, 32'h0000_0001);
    wait_drained();
    write_register(bfpe_pkg::CFG_NUM_BITS, 32'd100);
    write_register(bfpe_pkg::CFG_NUM_HASHES, 32'd3);
    @(negedge clk_i);
    add_probe(ACT_LOOKUP, 32'hFFFF_FFF0, 32'h0000_0001);
    add_probe(ACT_INSERT, $urandom(), $urandom());
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 3)
        0:       begin send_idle_pct = 21; recv_idle_pct = 74; end
        1:       begin send_idle_pct = 74; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      case (phase_bits[ph])
        -1:      bits_val = $urandom_range(1, 65536);
        -2:      bits_val = $urandom_range(2, 4096);
        default: bits_val = phase_bits[ph];
      endcase
      case (phase_hashes[ph])
        -1:      hashes_val = $urandom_range(1, 12);
        -3:      hashes_val = $urandom_range(0, 40);
        default: hashes_val = phase_hashes[ph];
      endcase
      // unused upper bits carry junk
      junk = $urandom();
      write_register(bfpe_pkg::CFG_NUM_BITS,
                     {junk[bfpe_pkg::CFG_DATA_W-1:bfpe_pkg::NBITS_W],
                      bits_val[bfpe_pkg::NBITS_W-1:0]});
      junk = $urandom();
      write_register(bfpe_pkg::CFG_NUM_HASHES,
                     {junk[bfpe_pkg::CFG_DATA_W-1:bfpe_pkg::NHASH_W],
                      hashes_val[bfpe_pkg::NHASH_W-1:0]});
      inserted_keys.delete();
      @(negedge clk_i);
      for (n = 0; n < PHASE_ITEMS; n++) probe_requests.push_back(next_random_probe());
      if (ph == 7) begin
        // keep offering while the receiver holds off
        @(posedge clk_i);
        stall_arm <= 1'b1;
        @(posedge clk_i);
        stall_arm <= 1'b0;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d inserts and %0d lookups (%0d possibly present), %0d register writes",
             inserts_done, lookups_done, present_hits, reg_writes);
    $display("%0d results checked, %0d mismatching fields", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bfpe_pkg.sv
rtl/core/bfpe_if.sv
rtl/core/bfpe_mod_unit.sv
rtl/core/bloom_filter_probe_engine.sv
tb/bloom_filter_probe_engine_tb.sv
